[hdl/pink_noise_shaping_filter_defines.svh]
// Assertion helpers for the pink noise shaping filter.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef PINK_NOISE_SHAPING_FILTER_DEFINES_SVH
`define PINK_NOISE_SHAPING_FILTER_DEFINES_SVH

// Same-cycle implication.
`define PNSF_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PNSF_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pnsf_pkg.sv]
`default_nettype none
package pnsf_pkg;

	localparam int COEF_W    = 18;
	localparam int COEF_FRAC = 17;
	localparam int NUM_POLES = 6;
	localparam int POLE_IDX_W = 3;
	localparam int NUM_STEPS = 16;
	localparam int STEP_W    = 4;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

	// Q1.17 coefficients
	localparam logic signed [COEF_W-1:0] G0 = 18'sd130923;
	localparam logic signed [COEF_W-1:0] G1 = 18'sd130196;
	localparam logic signed [COEF_W-1:0] G2 = 18'sd127009;
	localparam logic signed [COEF_W-1:0] G3 = 18'sd113574;
	localparam logic signed [COEF_W-1:0] G4 = 18'sd72090;
	localparam logic signed [COEF_W-1:0] G5 = -18'sd99824;
	localparam logic signed [COEF_W-1:0] D0 = 18'sd7277;
	localparam logic signed [COEF_W-1:0] D1 = 18'sd9840;
	localparam logic signed [COEF_W-1:0] D2 = 18'sd20166;
	localparam logic signed [COEF_W-1:0] D3 = 18'sd40696;
	localparam logic signed [COEF_W-1:0] D4 = 18'sd69855;
	localparam logic signed [COEF_W-1:0] D5 = -18'sd2215;
	localparam logic signed [COEF_W-1:0] DIRECT_COEF = 18'sd70281;
	localparam logic signed [COEF_W-1:0] DELAY_COEF  = 18'sd15195;
	localparam logic signed [COEF_W-1:0] OUT_SCALE   = 18'sd14418;
	localparam logic signed [COEF_W-1:0] NO_COEF     = 18'sd0;

	typedef enum logic [1:0] {
		A_STATE,
		A_WHITE,
		A_SUM
	} a_sel_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INIT,   // sum = delayed white term
		ACT_TMP,    // hold rounded feedback product
		ACT_POLE,   // write pole state, accumulate
		ACT_SUMW,   // accumulate direct white term
		ACT_DELAY,  // reload delayed white term
		ACT_OUT     // final rounding, result out
	} act_t;

	typedef enum logic {
		J_NEXT,
		J_HOLD      // wait here until the output register is free, then end
	} jmp_t;

	typedef struct packed {
		a_sel_t                  a_sel;
		logic signed [COEF_W-1:0] coef;
		logic [POLE_IDX_W-1:0]   rd_idx;
		logic [POLE_IDX_W-1:0]   wr_idx;
		act_t                    act;
		jmp_t                    jmp;
	} ucode_t;

	function automatic ucode_t mk_uc(
		input a_sel_t                   a_sel,
		input logic signed [COEF_W-1:0] coef,
		input logic [POLE_IDX_W-1:0]    rd_idx,
		input logic [POLE_IDX_W-1:0]    wr_idx,
		input act_t                     act,
		input jmp_t                     jmp
	);
		ucode_t u;
		u.a_sel  = a_sel;
		u.coef   = coef;
		u.rd_idx = rd_idx;
		u.wr_idx = wr_idx;
		u.act    = act;
		u.jmp    = jmp;
		return u;
	endfunction

	// Each step but the last issues one multiply; each step but the first retires the product of the step before.
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t u;
		case (step)
			4'd0:  u = mk_uc(A_STATE, G0, 3'd0, 3'd0, ACT_INIT,  J_NEXT);
			4'd1:  u = mk_uc(A_WHITE, D0, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd2:  u = mk_uc(A_STATE, G1, 3'd1, 3'd0, ACT_POLE,  J_NEXT);
			4'd3:  u = mk_uc(A_WHITE, D1, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd4:  u = mk_uc(A_STATE, G2, 3'd2, 3'd1, ACT_POLE,  J_NEXT);
			4'd5:  u = mk_uc(A_WHITE, D2, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd6:  u = mk_uc(A_STATE, G3, 3'd3, 3'd2, ACT_POLE,  J_NEXT);
			4'd7:  u = mk_uc(A_WHITE, D3, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd8:  u = mk_uc(A_STATE, G4, 3'd4, 3'd3, ACT_POLE,  J_NEXT);
			4'd9:  u = mk_uc(A_WHITE, D4, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd10: u = mk_uc(A_STATE, G5, 3'd5, 3'd4, ACT_POLE,  J_NEXT);
			4'd11: u = mk_uc(A_WHITE, D5, 3'd0, 3'd0, ACT_TMP,   J_NEXT);
			4'd12: u = mk_uc(A_WHITE, DIRECT_COEF, 3'd0, 3'd5, ACT_POLE, J_NEXT);
			4'd13: u = mk_uc(A_WHITE, DELAY_COEF,  3'd0, 3'd0, ACT_SUMW, J_NEXT);
			4'd14: u = mk_uc(A_SUM,   OUT_SCALE,   3'd0, 3'd0, ACT_DELAY, J_NEXT);
			4'd15: u = mk_uc(A_WHITE, NO_COEF,     3'd0, 3'd0, ACT_OUT,  J_HOLD);
			default: u = mk_uc(A_WHITE, NO_COEF,   3'd0, 3'd0, ACT_NONE, J_NEXT);
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

[hdl/pink_noise_shaping_filter.sv]
// Each accepted word runs through the 16-step microprogram on one multiplier, and the
// block takes no new word until the last step retires into the output register.
// A new word is taken in the cycle the last step retires, if the output register is free.
// Reset (arst_n low, async): sequencer idle, output empty, all seven filter states zero.
// start_of_signal zeroes the states as the word is accepted.
`default_nettype none
`include "pink_noise_shaping_filter_defines.svh"
module pink_noise_shaping_filter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 28
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] white_sample,
	input  wire logic                           start_of_signal,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      pink_sample,
	output logic                                clipped
);
	import pnsf_pkg::*;

	// Sum of eight state-sized terms needs three guard bits; one spare.
	localparam int SUM_W = STATE_WIDTH + 4;
	localparam int PW    = SUM_W + COEF_W;   // product width

	// Shift that brings white * coef into state format; may be negative
	// (exact left shift) for narrow samples and wide states.
	localparam int W_SHIFT = (SAMPLE_WIDTH - 1) + COEF_FRAC - (STATE_WIDTH - 8);
	localparam int W_R     = (W_SHIFT > 0) ? W_SHIFT : 0;
	localparam int W_L     = (W_SHIFT < 0) ? -W_SHIFT : 0;
	localparam int W_RM1   = (W_R > 0) ? W_R - 1 : 0;
	// Sum (state format) * Q1.17 back into sample format.
	localparam int O_SHIFT = (STATE_WIDTH - 8) + COEF_FRAC - (SAMPLE_WIDTH - 1);

	localparam logic signed [PW:0] ONE    = {{PW{1'b0}}, 1'b1};
	localparam logic signed [PW:0] C_HALF = ONE <<< (COEF_FRAC - 1);
	localparam logic signed [PW:0] W_HALF = (W_R > 0) ? (ONE <<< W_RM1) : '0;
	localparam logic signed [PW:0] O_HALF = ONE <<< (O_SHIFT - 1);

	localparam logic signed [PW:0] ST_MAX =
		{{(PW - STATE_WIDTH + 2){1'b0}}, {(STATE_WIDTH - 1){1'b1}}};
	localparam logic signed [PW:0] ST_MIN = ~ST_MAX;
	localparam logic signed [PW:0] SMP_MAX =
		{{(PW - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [PW:0] SMP_MIN = ~SMP_MAX;

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(
		input logic signed [PW:0] v
	);
		logic signed [STATE_WIDTH-1:0] r;
		if (v > ST_MAX)
			r = ST_MAX[STATE_WIDTH-1:0];
		else if (v < ST_MIN)
			r = ST_MIN[STATE_WIDTH-1:0];
		else
			r = v[STATE_WIDTH-1:0];
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	logic                busy_q;
	logic [STEP_W-1:0]   step_q;
	ucode_t              uc;
	logic                acc;
	logic                fin_go;

	assign uc = ucode_rom(step_q);

	// Conditional jump: the last step holds until the output register can take the word.
	assign fin_go   = busy_q && (uc.jmp == J_HOLD) && (!out_valid || !out_stall);
	assign in_stall = busy_q && !fin_go;
	assign acc      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (acc) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (fin_go) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q && uc.jmp == J_NEXT) begin
			step_q <= step_q + 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// Datapath: one shared multiplier, product registered
	// ---------------------------------------------------------------
	logic signed [SAMPLE_WIDTH-1:0] w_q;
	logic signed [STATE_WIDTH-1:0]  pole_q [NUM_POLES];
	logic signed [STATE_WIDTH-1:0]  dly_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [STATE_WIDTH:0]    tmp_q;
	logic signed [PW-1:0]           prod_q;

	logic signed [SUM_W-1:0]        a_op;
	logic signed [PW:0]             p_ext;
	logic signed [PW:0]             rc;      // rounded to state, feedback product
	logic signed [PW:0]             rw;      // rounded to state, white product
	logic signed [PW:0]             ro;      // rounded to sample, output product
	logic signed [PW:0]             nv;
	logic signed [STATE_WIDTH-1:0]  nv_sat;
	logic signed [STATE_WIDTH-1:0]  dly_sat;

	always_comb begin
		case (uc.a_sel)
			A_STATE: a_op = SUM_W'(pole_q[uc.rd_idx]);
			A_WHITE: a_op = SUM_W'(w_q);
			A_SUM:   a_op = sum_q;
			default: a_op = '0;
		endcase
	end

	// The output product must stay put while the last step waits on out_stall.
	always_ff @(posedge clk) begin
		if (acc)
			w_q <= white_sample;
		if (busy_q && uc.jmp == J_NEXT)
			prod_q <= a_op * uc.coef;
	end

	// Round half up, then floor: add half an LSB and shift arithmetically.
	assign p_ext   = (PW + 1)'(prod_q);
	assign rc      = (p_ext + C_HALF) >>> COEF_FRAC;
	assign rw      = ((p_ext <<< W_L) + W_HALF) >>> W_R;
	assign ro      = (p_ext + O_HALF) >>> O_SHIFT;
	assign nv      = (PW + 1)'(tmp_q) + rw;
	assign nv_sat  = sat_state(nv);
	assign dly_sat = sat_state(rw);

	// Filter states: reset and start flag clear them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POLES; i++)
				pole_q[i] <= '0;
			dly_q <= '0;
		end else if (acc && start_of_signal) begin
			for (int i = 0; i < NUM_POLES; i++)
				pole_q[i] <= '0;
			dly_q <= '0;
		end else if (busy_q) begin
			case (uc.act)
				ACT_POLE:  pole_q[uc.wr_idx] <= nv_sat;
				ACT_DELAY: dly_q <= dly_sat;
				default: ;
			endcase
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (uc.act)
				ACT_INIT: sum_q <= SUM_W'(dly_q);
				ACT_TMP:  tmp_q <= rc[STATE_WIDTH:0];
				ACT_POLE: sum_q <= sum_q + SUM_W'(nv_sat);
				ACT_SUMW: sum_q <= sum_q + SUM_W'(rw);
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] pink_q;
	logic                           clip_q;
	logic signed [SAMPLE_WIDTH-1:0] pink_sat;
	logic                           pink_clip;

	always_comb begin
		pink_clip = 1'b0;
		if (ro > SMP_MAX) begin
			pink_sat  = SMP_MAX[SAMPLE_WIDTH-1:0];
			pink_clip = 1'b1;
		end else if (ro < SMP_MIN) begin
			pink_sat  = SMP_MIN[SAMPLE_WIDTH-1:0];
			pink_clip = 1'b1;
		end else begin
			pink_sat = ro[SAMPLE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fin_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			pink_q <= pink_sat;
			clip_q <= pink_clip;
		end
	end

	assign out_valid   = out_valid_q;
	assign pink_sample = pink_q;
	assign clipped     = clip_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`PNSF_ASSERT_NXT(a_accept_restarts, acc, busy_q && step_q == '0,
		"accepted word did not start the microprogram at step zero")
	`PNSF_ASSERT_NXT(a_step_advances, busy_q && uc.jmp == J_NEXT && !acc,
		busy_q && step_q == $past(step_q) + 1'b1, "microprogram skipped or lost a step")
	`PNSF_ASSERT_IMP(a_result_from_last, $rose(out_valid_q),
		$past(busy_q) && $past(step_q) == LAST_STEP, "result appeared before the last step")

endmodule
`default_nettype wire

[dv/pink_sample_checker.sv]
`default_nettype none
module pink_sample_checker #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 28
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] white_sample,
	input  wire logic                           start_of_signal,
	input  wire logic                           out_valid,
	input  wire logic                           out_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] pink_sample,
	input  wire logic                           clipped,
	output int                                  mismatches,
	output int                                  outstanding
);

	localparam int NUM_SECTIONS = 6;
	localparam int COEF_FRAC    = 17;
	localparam int SAMPLE_FRAC  = SAMPLE_WIDTH - 1;
	localparam int STATE_FRAC   = STATE_WIDTH - 8;
	localparam int WHITE_SHIFT  = SAMPLE_FRAC + COEF_FRAC - STATE_FRAC;
	localparam int PINK_SHIFT   = STATE_FRAC + COEF_FRAC - SAMPLE_FRAC;

	// Q1.17 taps
	localparam longint DIRECT_TAP = 70281;
	localparam longint DELAY_TAP  = 15195;
	localparam longint PINK_GAIN  = 14418;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] pink;
		logic                           clip;
	} pink_word_t;

	longint     lowpass_state [NUM_SECTIONS];
	longint     delayed_white;
	pink_word_t pink_expected [$];
	int         fail_count;

	function automatic longint feedback_tap(input int idx);
		case (idx)
			0:       return 130923;
			1:       return 130196;
			2:       return 127009;
			3:       return 113574;
			4:       return 72090;
			default: return -99824;
		endcase
	endfunction

	function automatic longint drive_tap(input int idx);
		case (idx)
			0:       return 7277;
			1:       return 9840;
			2:       return 20166;
			3:       return 40696;
			4:       return 69855;
			default: return -2215;
		endcase
	endfunction

	// scale by 2^-s, round half up
	function automatic longint round_shift(input longint v, input int s);
		if (s <= 0)
			return v <<< (-s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input int width);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (width - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	// Advances the filter by one white sample and returns the pink word.
	function automatic pink_word_t next_pink_word(
		input logic signed [SAMPLE_WIDTH-1:0] white,
		input logic                           restart
	);
		longint     w;
		longint     acc;
		longint     raw;
		longint     sat;
		pink_word_t r;
		int         i;
		w = white;
		if (restart) begin
			for (i = 0; i < NUM_SECTIONS; i++)
				lowpass_state[i] = 0;
			delayed_white = 0;
		end
		acc = 0;
		for (i = 0; i < NUM_SECTIONS; i++) begin
			lowpass_state[i] = clamp(round_shift(feedback_tap(i) * lowpass_state[i], COEF_FRAC)
				+ round_shift(w * drive_tap(i), WHITE_SHIFT), STATE_WIDTH);
			acc += lowpass_state[i];
		end
		acc += delayed_white;
		acc += round_shift(w * DIRECT_TAP, WHITE_SHIFT);
		raw = round_shift(acc * PINK_GAIN, PINK_SHIFT);
		sat = clamp(raw, SAMPLE_WIDTH);
		delayed_white = clamp(round_shift(w * DELAY_TAP, WHITE_SHIFT), STATE_WIDTH);
		r.pink = sat[SAMPLE_WIDTH-1:0];
		r.clip = (sat != raw);
		return r;
	endfunction

	initial begin
		mismatches  = 0;
		outstanding = 0;
		fail_count  = 0;
		delayed_white = 0;
		for (int i = 0; i < NUM_SECTIONS; i++)
			lowpass_state[i] = 0;
	end

	always @(posedge clk) begin
		pink_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SECTIONS; i++)
				lowpass_state[i] = 0;
			delayed_white = 0;
			pink_expected.delete();
		end else begin
			// retire first so a zero-latency result cannot match its own word
			if (out_valid && !out_stall) begin
				if (pink_expected.size() == 0) begin
					$display("%0t: pink word %0d/%0d with none expected", $time,
						pink_sample, clipped);
					fail_count++;
				end else begin
					want = pink_expected.pop_front();
					if (pink_sample !== want.pink) begin
						$display("%0t: pink_sample expected %0d actual %0d", $time,
							want.pink, pink_sample);
						fail_count++;
					end
					if (clipped !== want.clip) begin
						$display("%0t: clipped expected %0d actual %0d", $time,
							want.clip, clipped);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				pink_expected.push_back(next_pink_word(white_sample, start_of_signal));
		end
		mismatches  <= fail_count;
		outstanding <= pink_expected.size();
	end

endmodule
`default_nettype wire

[dv/tb_pink_noise_shaping_filter.sv]
`default_nettype none
// Pink noise filter bench: drives white samples through the valid/stall
// input channel, throttles the output channel, and leaves all prediction
// and comparison to pink_sample_checker.
module tb_pink_noise_shaping_filter;

	localparam int SAMPLE_W = 16;
	localparam int STATE_W  = 28;
	localparam int SAMPLE_MAX = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN = -(1 << (SAMPLE_W - 1));

	localparam int RANDOM_WORDS = 850;
	localparam int HOLD_CYCLES  = 300;   // long output hold-off, fills the block
	localparam int DRAIN_CYCLES = 40;    // margin after the last expected word retires
	// slowest legal run is the microprogram for every word plus long gaps on
	// both sides; keep several times that
	localparam int CYCLE_LIMIT  = 600000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] white_sample;
	logic                       start_of_signal;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] pink_sample;
	logic                       clipped;

	int mismatches;
	int outstanding;
	int cycle_count;

	// idle odds in percent, changed per phase by the stimulus
	int tx_idle_pct;
	int rx_idle_pct;
	// the stimulus bumps hold_requests; the receiver serves it on its own
	int hold_requests = 0;
	int hold_served   = 0;
	int hold_left     = 0;

	initial forever #5 clk = ~clk;

	pink_noise_shaping_filter #(
		.SAMPLE_WIDTH (SAMPLE_W),
		.STATE_WIDTH  (STATE_W)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.white_sample    (white_sample),
		.start_of_signal (start_of_signal),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pink_sample     (pink_sample),
		.clipped         (clipped)
	);

	pink_sample_checker #(
		.SAMPLE_WIDTH (SAMPLE_W),
		.STATE_WIDTH  (STATE_W)
	) u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.white_sample    (white_sample),
		.start_of_signal (start_of_signal),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pink_sample     (pink_sample),
		.clipped         (clipped),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// Receiver: random stall per cycle, or a long hold-off when one is asked for.
	// The hold-off is counted here, not in the stimulus, so the sender keeps
	// offering words while the block backs up and raises in_stall.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// Offers one word; returns at the edge where it is taken. Idle cycles
	// are drawn one at a time so gaps land on every step of the microprogram.
	// valid stays high between back-to-back words.
	task automatic send_word(input logic signed [SAMPLE_W-1:0] w, input logic sos);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		white_sample    <= w;
		start_of_signal <= sos;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// White sample for position pos of a run of the given flavor.
	function automatic logic signed [SAMPLE_W-1:0] pick_white(input int flavor, input int pos);
		int v;
		case (flavor)
			0:       v = $urandom_range(SAMPLE_MAX, SAMPLE_MAX * 3 / 4);      // drives to +clip
			1:       v = -int'($urandom_range(-SAMPLE_MIN, SAMPLE_MAX * 3 / 4)); // drives to -clip
			2: begin
				case ($urandom_range(3))
					0:       v = SAMPLE_MAX;
					1:       v = SAMPLE_MIN;
					2:       v = 0;
					default: v = -1;
				endcase
			end
			3:       v = (pos % 2) ? SAMPLE_MAX : SAMPLE_MIN;  // excites the negative pole
			4:       v = int'($urandom_range(255)) - 128;
			default: v = $urandom;
		endcase
		return SAMPLE_W'(v);
	endfunction

	// Signals: mostly a start flag then a run of same-flavor samples. Long
	// same-sign runs are what push the slow poles far enough to saturate the
	// output; the rest is short runs, noise, and stray or missing start flags.
	task automatic run_signals(input int count);
		int left;
		int run_len;
		int flavor;
		int pos;
		logic sos;
		left = count;
		while (left > 0) begin
			flavor = $urandom_range(9);
			if (flavor < 2)
				run_len = $urandom_range(260, 160);
			else
				run_len = $urandom_range(40, 3);
			if (run_len > left)
				run_len = left;
			for (pos = 0; pos < run_len; pos++) begin
				if (pos == 0)
					sos = ($urandom_range(9) != 0);
				else
					sos = ($urandom_range(59) == 0);
				send_word(pick_white(flavor, pos), sos);
			end
			left -= run_len;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid        <= 1'b0;
		white_sample    <= '0;
		start_of_signal <= 1'b0;
		tx_idle_pct = 21;
		rx_idle_pct = 83;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: full-scale ends, sign boundary, bit patterns, start flag
		send_word('0, 1'b0);
		send_word(SAMPLE_W'(SAMPLE_MAX), 1'b0);
		send_word(SAMPLE_W'(SAMPLE_MIN), 1'b0);
		send_word(SAMPLE_W'(SAMPLE_MAX), 1'b0);
		send_word(SAMPLE_W'(-1), 1'b0);
		send_word(SAMPLE_W'(1), 1'b0);
		send_word(SAMPLE_W'(SAMPLE_MIN), 1'b1);  // restart mid-stream
		send_word(SAMPLE_W'(SAMPLE_MIN), 1'b0);
		send_word(SAMPLE_W'(SAMPLE_MIN), 1'b0);
		send_word(16'sh5555, 1'b1);
		send_word(16'shAAAA, 1'b0);
		send_word('0, 1'b1);                      // cleared states, zero in: zero out
		send_word(SAMPLE_W'(SAMPLE_MAX), 1'b1);
		send_word(SAMPLE_W'(SAMPLE_MAX), 1'b1);  // back-to-back restarts
		send_word(SAMPLE_W'(-1), 1'b1);
		send_word(SAMPLE_W'(SAMPLE_MAX), 1'b0);

		// phase 1: slow receiver
		run_signals(RANDOM_WORDS / 3);
		// phase 2: slow sender
		tx_idle_pct = 83;
		rx_idle_pct = 21;
		run_signals(RANDOM_WORDS / 3);
		// phase 3: full rate, opened by a long output hold-off
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests++;
		run_signals(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));
		in_valid <= 1'b0;

		// outstanding is registered, so the last push is already counted here
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog: a lost result leaves outstanding stuck and ends up here
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
